// ----- src/ostt_pkg.sv -----
// Shared types and constants of the one-shot timer table.
package ostt_pkg;

  localparam int unsigned SLOTS    = 32;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned S_DATA_W = ID_W + 2 * TIME_W;
  localparam int unsigned M_DATA_W = ID_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_SCHEDULE = 2'd0,
    CMD_CANCEL   = 2'd1,
    CMD_TICK     = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_SCHEDULED  = 3'd0,
    STS_TABLE_FULL = 3'd1,
    STS_CANCELLED  = 3'd2,
    STS_NOT_FOUND  = 3'd3,
    STS_FIRED      = 3'd4
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture the input word
    logic exec;   // apply schedule or cancel and post its result
    logic scan;   // latch the set of due slots for a tick
    logic fire;   // emit the lowest due slot and free it
  } ostt_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic due_any;
    logic fire_last;
    logic out_free;
  } ostt_sts_t;

endpackage

// ----- src/ostt_dp.sv -----
// Datapath of the one-shot timer table: slot storage, match logic and output register.
module ostt_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ostt_pkg::ostt_cmd_t              cmd_i,
  output ostt_pkg::ostt_sts_t              sts_o,
  // timer_id [7:0], expiry_time [39:8], current_time [71:40]
  input  logic [ostt_pkg::S_DATA_W-1:0]    s_axis_tdata_i,
  // command [1:0]
  input  logic [ostt_pkg::CMD_W-1:0]       s_axis_tuser_i,
  input  logic                             m_axis_tready_i,
  output logic                             m_axis_tvalid_o,
  // fired_id [7:0]
  output logic [ostt_pkg::M_DATA_W-1:0]    m_axis_tdata_o,
  // status [2:0]
  output logic [ostt_pkg::STATUS_W-1:0]    m_axis_tuser_o,
  output logic                             m_axis_tlast_o
);
  import ostt_pkg::*;

  cmd_e              cmd_q;
  logic [ID_W-1:0]   id_q;
  logic [TIME_W-1:0] expiry_q;
  logic [TIME_W-1:0] now_q;

  logic [ID_W-1:0]   owner_q    [SLOTS];
  logic [TIME_W-1:0] deadline_q [SLOTS];

  logic [SLOTS-1:0]  busy_q, busy_d;
  logic [SLOTS-1:0]  due_q, due_d;
  logic              out_valid_q, out_valid_d;
  status_e           out_status_q;
  logic [ID_W-1:0]   out_id_q;
  logic              out_last_q;

  logic [SLOTS-1:0]  match, free, match_sel, free_sel, wr_sel, due_now, fire_sel;
  logic              has_match, has_free, out_free;
  logic [ID_W-1:0]   fire_id;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match[i]   = busy_q[i] && (owner_q[i] == id_q);
      due_now[i] = busy_q[i] && (deadline_q[i] <= now_q);
    end
  end

  // isolate the lowest set bit of each candidate vector
  assign free      = ~busy_q;
  assign match_sel = match & (~match + 1'b1);
  assign free_sel  = free & (~free + 1'b1);
  assign fire_sel  = due_q & (~due_q + 1'b1);
  assign has_match = |match;
  assign has_free  = |free;
  assign wr_sel    = has_match ? match_sel : free_sel;

  always_comb begin
    fire_id = '0;
    for (int i = 0; i < SLOTS; i++) begin
      fire_id = fire_id | (owner_q[i] & {ID_W{fire_sel[i]}});
    end
  end

  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    busy_d      = busy_q;
    due_d       = due_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.exec) begin
      out_valid_d = 1'b1;
      if (cmd_q == CMD_CANCEL) begin
        busy_d = busy_q & ~match;
      end else if (!has_match) begin
        busy_d = busy_q | free_sel;
      end
    end
    if (cmd_i.scan) begin
      due_d = due_now;
    end
    if (cmd_i.fire) begin
      out_valid_d = 1'b1;
      busy_d      = busy_q & ~fire_sel;
      due_d       = due_q & ~fire_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= '0;
      due_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      due_q       <= due_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q    <= cmd_e'(s_axis_tuser_i);
      id_q     <= s_axis_tdata_i[ID_W-1:0];
      expiry_q <= s_axis_tdata_i[ID_W+TIME_W-1:ID_W];
      now_q    <= s_axis_tdata_i[S_DATA_W-1:ID_W+TIME_W];
    end
    if (cmd_i.exec && cmd_q == CMD_SCHEDULE) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (wr_sel[i]) begin
          deadline_q[i] <= expiry_q;
          owner_q[i]    <= id_q;
        end
      end
    end
    if (cmd_i.exec) begin
      out_id_q   <= id_q;
      out_last_q <= 1'b1;
      if (cmd_q == CMD_CANCEL) begin
        out_status_q <= has_match ? STS_CANCELLED : STS_NOT_FOUND;
      end else begin
        out_status_q <= (has_match || has_free) ? STS_SCHEDULED : STS_TABLE_FULL;
      end
    end
    if (cmd_i.fire) begin
      out_status_q <= STS_FIRED;
      out_id_q     <= fire_id;
      out_last_q   <= ((due_q & ~fire_sel) == '0);
    end
  end

  assign sts_o.cmd       = cmd_q;
  assign sts_o.due_any   = |due_q;
  assign sts_o.fire_last = ((due_q & ~fire_sel) == '0);
  assign sts_o.out_free  = out_free;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_id_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef NO_ASSERTIONS
  a_fire_has_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fire |-> (due_q != '0))
    else $error("fire with no due slot");

  a_push_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec || cmd_i.fire) |-> out_free)
    else $error("output word overwritten before it was taken");

  a_due_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (due_q & ~busy_q) == '0)
    else $error("due slot is not busy");

  a_fire_drops_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fire |=> ($countones(due_q) + 1 == $past($countones(due_q))))
    else $error("fire did not retire exactly one slot");
`endif

endmodule

// ----- src/ostt_ctrl.sv -----
// Controller of the one-shot timer table: sequences one command at a time.
module ostt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  ostt_pkg::ostt_sts_t sts_i,
  output ostt_pkg::ostt_cmd_t cmd_o
);
  import ostt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIRE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    s_axis_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (sts_i.cmd)
          CMD_SCHEDULE, CMD_CANCEL: begin
            // hold until the output register can take the word
            if (sts_i.out_free) begin
              cmd_o.exec = 1'b1;
              state_d    = ST_IDLE;
            end
          end
          CMD_TICK: begin
            cmd_o.scan = 1'b1;
            state_d    = ST_FIRE;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_FIRE: begin
        if (!sts_i.due_any) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.fire = 1'b1;
          if (sts_i.fire_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/one_shot_timer_table.sv -----
// Schedule and cancel: the word is loaded on accept, then applied and its result word registered in the output.
// Tick: the word is loaded on accept, all due slots are latched, then one fired word per cycle
//   in slot order while the output register can take it; a tick with no due slots posts no word.
// A new word is accepted as soon as the previous command's last result sits in the output
//   register; a stalled output holds the controller before the next result is posted.
// Reset (rst_ni low, asynchronous) frees every slot and empties the output register.
module one_shot_timer_table (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // timer_id [7:0], expiry_time [39:8], current_time [71:40]
  input  logic [ostt_pkg::S_DATA_W-1:0]    s_axis_tdata_i,
  // command [1:0]
  input  logic [ostt_pkg::CMD_W-1:0]       s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // fired_id [7:0]
  output logic [ostt_pkg::M_DATA_W-1:0]    m_axis_tdata_o,
  // status [2:0]
  output logic [ostt_pkg::STATUS_W-1:0]    m_axis_tuser_o,
  output logic                             m_axis_tlast_o
);
  import ostt_pkg::*;

  ostt_cmd_t cmd;
  ostt_sts_t sts;

  ostt_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  ostt_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// ----- test/ostt_checker.sv -----
// Checker for the one-shot timer table: keeps its own slot table and matches every output word.
module ostt_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_tvalid_i,
  input  logic                              s_tready_i,
  // timer_id [7:0], expiry_time [39:8], current_time [71:40]
  input  logic [ostt_pkg::S_DATA_W-1:0]     s_tdata_i,
  // command [1:0]
  input  logic [ostt_pkg::CMD_W-1:0]        s_tuser_i,
  input  logic                              m_tvalid_i,
  input  logic                              m_tready_i,
  // fired_id [7:0]
  input  logic [ostt_pkg::M_DATA_W-1:0]     m_tdata_i,
  // status [2:0]
  input  logic [ostt_pkg::STATUS_W-1:0]     m_tuser_i,
  input  logic                              m_tlast_i,
  output int unsigned                       errors_o,
  output int unsigned                       owed_o,
  output int unsigned                       words_o,
  output int unsigned                       fired_o,
  output int unsigned                       full_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ostt_pkg::*;

  typedef struct {
    status_e         status;
    logic [ID_W-1:0] id;
    logic            last;
  } timer_result_t;

  timer_result_t owed_results[$];
  timer_result_t oldest;

  bit                slot_in_use [SLOTS];
  logic [ID_W-1:0]   slot_owner  [SLOTS];
  logic [TIME_W-1:0] slot_expiry [SLOTS];

  int unsigned n_errors = 0;
  int unsigned n_words  = 0;
  int unsigned n_fired  = 0;
  int unsigned n_full   = 0;

  function automatic void owe(status_e status, logic [ID_W-1:0] id, logic last);
    timer_result_t r;
    r.status = status;
    r.id     = id;
    r.last   = last;
    owed_results.push_back(r);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      n_errors++;
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // Apply one command to the mirrored table and queue the words it owes.
  function automatic void advance_table(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                        logic [TIME_W-1:0] due, logic [TIME_W-1:0] now);
    int hit_slot;
    int free_slot;
    int n_due;
    int k;
    bit found;
    hit_slot  = -1;
    free_slot = -1;
    n_due     = 0;
    k         = 0;
    found     = 1'b0;
    case (cmd)
      CMD_SCHEDULE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_in_use[i] && slot_owner[i] == id && hit_slot < 0) hit_slot = i;
          if (!slot_in_use[i] && free_slot < 0) free_slot = i;
        end
        if (hit_slot >= 0) begin
          slot_expiry[hit_slot] = due;
          owe(STS_SCHEDULED, id, 1'b1);
        end else if (free_slot < 0) begin
          owe(STS_TABLE_FULL, id, 1'b1);
        end else begin
          slot_in_use[free_slot] = 1'b1;
          slot_owner[free_slot]  = id;
          slot_expiry[free_slot] = due;
          owe(STS_SCHEDULED, id, 1'b1);
        end
      end
      CMD_CANCEL: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_in_use[i] && slot_owner[i] == id) begin
            slot_in_use[i] = 1'b0;
            found = 1'b1;
          end
        end
        if (found) owe(STS_CANCELLED, id, 1'b1);
        else owe(STS_NOT_FOUND, id, 1'b1);
      end
      CMD_TICK: begin
        for (int i = 0; i < SLOTS; i++)
          if (slot_in_use[i] && slot_expiry[i] <= now) n_due++;
        // fire in slot order, mark the final one
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_in_use[i] && slot_expiry[i] <= now) begin
            k++;
            owe(STS_FIRED, slot_owner[i], k == n_due);
            slot_in_use[i] = 1'b0;
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) slot_in_use[i] = 1'b0;
      owed_results.delete();
    end else begin
      if (s_tvalid_i && s_tready_i)
        advance_table(s_tuser_i, s_tdata_i[ID_W-1:0], s_tdata_i[ID_W +: TIME_W],
                      s_tdata_i[ID_W+TIME_W +: TIME_W]);
      if (m_tvalid_i && m_tready_i) begin
        n_words++;
        if (owed_results.size() == 0) begin
          n_errors++;
          $error("unexpected result word: status %0d, fired_id %0d, last_result %0d",
                 m_tuser_i, m_tdata_i, m_tlast_i);
        end else begin
          oldest = owed_results.pop_front();
          check_field("status", oldest.status, m_tuser_i);
          check_field("fired_id", oldest.id, m_tdata_i);
          check_field("last_result", oldest.last, m_tlast_i);
          if (m_tuser_i == STS_FIRED) n_fired++;
          if (m_tuser_i == STS_TABLE_FULL) n_full++;
        end
      end
    end
    errors_o <= n_errors;
    owed_o   <= owed_results.size();
    words_o  <= n_words;
    fired_o  <= n_fired;
    full_o   <= n_full;
  end

endmodule

// ----- test/one_shot_timer_table_tb.sv -----
// Testbench top for the one-shot timer table: stimulus, output flow control and verdict.
module one_shot_timer_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ostt_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned FILL_LEN      = SLOTS + 4;

  logic                clk_i;
  logic                rst_ni   = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata  = '0;
  logic [CMD_W-1:0]    s_tuser  = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0] m_tuser;
  logic                m_tlast;

  int unsigned errors, owed, words, fired, full;
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_requests  = 0;
  int unsigned holds_served   = 0;
  int unsigned hold_left      = 0;
  int unsigned commands_sent  = 0;
  logic [TIME_W-1:0] tick_time = '0;

  one_shot_timer_table uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  ostt_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .m_tuser_i  (m_tuser),
    .m_tlast_i  (m_tlast),
    .errors_o   (errors),
    .owed_o     (owed),
    .words_o    (words),
    .fired_o    (fired),
    .full_o     (full)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Output side: random stalls, plus a long hold-off whenever one is requested.
  initial forever begin
    @(posedge clk_i);
    if (hold_left == 0 && holds_served != hold_requests) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic send_word(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                           logic [TIME_W-1:0] due, logic [TIME_W-1:0] now);
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {now, due, id};
    do @(posedge clk_i); while (!s_tready);
    if (cmd != CMD_UNUSED) commands_sent++;
  endtask

  // Drop valid and hold until every owed word has come out.
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (owed != 0);
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    case ($urandom_range(11))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h01;
      3: return 8'h80;
      4: return 8'h5A;
      5: return 8'hA5;
      6: return 8'h7F;
      7: return 8'h10;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_random();
    int unsigned pick;
    logic [ID_W-1:0] id;
    logic [TIME_W-1:0] t;
    pick = $urandom_range(99);
    id   = pick_id();
    if (pick < 45) begin
      case ($urandom_range(9))
        0: t = '1;
        1: t = '0;
        2: t = $urandom;
        default: t = tick_time + $urandom_range(400);
      endcase
      send_word(CMD_SCHEDULE, id, t, $urandom);
    end else if (pick < 62) begin
      send_word(CMD_CANCEL, id, $urandom, $urandom);
    end else if (pick < 92) begin
      case ($urandom_range(9))
        0: t = '1;
        1: t = $urandom;
        default: begin
          tick_time = tick_time + $urandom_range(150);
          t = tick_time;
        end
      endcase
      send_word(CMD_TICK, 8'($urandom), $urandom, t);
    end else begin
      send_word(CMD_UNUSED, 8'($urandom), $urandom, $urandom);
    end
  endtask

  task automatic send_randoms(int unsigned n);
    int unsigned target;
    target = commands_sent + n;
    while (commands_sent < target) send_random();
  endtask

  // Overfill the table, then fire everything with the latest possible time.
  task automatic fill_table();
    for (int k = 0; k < FILL_LEN; k++)
      send_word(CMD_SCHEDULE, 8'($urandom), tick_time + $urandom_range(500), $urandom);
    send_word(CMD_TICK, 8'($urandom), $urandom, '1);
  endtask

  task automatic run_phase(int unsigned src_pct, int unsigned sink_pct, int unsigned n,
                           bit with_fill);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    send_randoms(n / 2);
    if (with_fill) fill_table();
    send_randoms(n - n / 2);
    wait_drain();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table: tick and cancel find nothing
    send_word(CMD_TICK, '1, '1, '1);
    send_word(CMD_CANCEL, 8'h00, '0, '0);
    // extremes of id and expiry, then an update of an existing id
    send_word(CMD_SCHEDULE, 8'h00, '0, '1);
    send_word(CMD_SCHEDULE, 8'hFF, '1, '0);
    send_word(CMD_SCHEDULE, 8'h00, 32'd5, '0);
    send_word(CMD_UNUSED, 8'hC3, 32'hDEAD_BEEF, '0);
    send_word(CMD_TICK, '0, '0, 32'd4);
    send_word(CMD_TICK, '0, '0, 32'd5);
    send_word(CMD_CANCEL, 8'hFF, '0, '0);
    send_word(CMD_CANCEL, 8'hFF, '0, '0);
    // several due on one tick, fired in slot order
    send_word(CMD_SCHEDULE, 8'h5A, 32'd100, '0);
    send_word(CMD_SCHEDULE, 8'hA5, 32'd100, '0);
    send_word(CMD_SCHEDULE, 8'h3C, 32'd50, '0);
    send_word(CMD_TICK, '1, '1, 32'd100);
    send_word(CMD_TICK, '0, '0, '1);
    // deadline equal to the current time, at both ends of the range
    send_word(CMD_SCHEDULE, 8'h11, '1, '0);
    send_word(CMD_TICK, '0, '0, '1);
    send_word(CMD_SCHEDULE, 8'h22, '0, '1);
    send_word(CMD_TICK, '1, '1, '0);
    wait_drain();

    // long output hold-off while the table is overfilled, so the input backs up
    hold_requests++;
    fill_table();
    wait_drain();

    run_phase(0, 0, 30, 1'b1);
    run_phase(87, 0, 30, 1'b0);
    run_phase(0, 87, 30, 1'b1);
    run_phase(9, 9, 40, 1'b0);

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Ran %0d commands: directed corners, table overfill with a long output stall,",
             commands_sent);
    $display("and four idle mixes; %0d result words checked, %0d fired, %0d table-full.",
             words, fired, full);
    if (errors == 0 && owed == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout with %0d words still owed", owed);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
